/* src/lrp_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// lrp_pkg: shared definitions for the reply line parser
// Character codes, field sizing, sector geometry and the result record.
// ---------------------------------------------------------------------------
package lrp_pkg;

    localparam int FIELD_BUFFER_BYTES = 16;
    localparam int SECTOR_COUNT       = 8;
    localparam int SECTOR_WIDTH_DEG   = 45;

    localparam int CHAR_W  = 8;
    localparam int VALUE_W = 24;
    localparam int LEN_W   = $clog2(FIELD_BUFFER_BYTES);
    localparam int IDX_W   = 3;

    localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;
    localparam logic [CHAR_W-1:0] CH_QUERY = 8'h3F;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

    typedef struct packed {
        logic [VALUE_W-1:0] first_value;
        logic [VALUE_W-1:0] second_value;
        logic               second_present;
        logic [IDX_W-1:0]   sector_index;
        logic               sector_valid;
    } t_result;

endpackage
`default_nettype wire

/* src/lidar_reply_line_parser.sv */
`default_nettype none
// A result is registered at the edge accepting its line end, in output or skid.
// One character per cycle unless stalled; parser state updates at each accept.
// A result waiting on the output spills into a one-deep skid register, and the
// input stalls only while that skid register is occupied.
// Reset (synchronous, active low) clears the line state and both output valids.
// ---------------------------------------------------------------------------
// lidar_reply_line_parser: reply line splitter with value and sector output
// Splits lines into two fields; one transaction per line with a first field.
// ---------------------------------------------------------------------------
module lidar_reply_line_parser (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic [lrp_pkg::CHAR_W-1:0]      i_rx_char,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic [lrp_pkg::VALUE_W-1:0]          o_first_value,
    output logic [lrp_pkg::VALUE_W-1:0]          o_second_value,
    output logic                                 o_second_present,
    output logic [lrp_pkg::IDX_W-1:0]            o_sector_index,
    output logic                                 o_sector_valid
);

    logic             r_out_valid, r_skid_valid;
    lrp_pkg::t_result r_out, r_skid, res;
    logic             res_valid, accept, out_free;

    assign o_in_stall = r_skid_valid;
    assign accept     = i_in_valid && !r_skid_valid;
    assign out_free   = !r_out_valid || !i_out_stall;

    lrp_parser u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_char_accept  (accept),
        .i_rx_char      (i_rx_char),
        .o_result       (res),
        .o_result_valid (res_valid)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid  <= r_skid_valid || res_valid;
            r_skid_valid <= 1'b0;
        end else if (res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : res;
        end else if (res_valid) begin
            r_skid <= res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_first_value    = r_out.first_value;
    assign o_second_value   = r_out.second_value;
    assign o_second_present = r_out.second_present;
    assign o_sector_index   = r_out.sector_index;
    assign o_sector_valid   = r_out.sector_valid;

endmodule
`default_nettype wire

/* src/lrp_parser.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// lrp_parser: per-character line state and field conversion
// Holds the line state and both field accumulators; gives the result of a
// line end combinationally in the cycle the character is accepted.
// ---------------------------------------------------------------------------
module lrp_parser (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_char_accept,
    input  wire logic [lrp_pkg::CHAR_W-1:0]    i_rx_char,
    output lrp_pkg::t_result                   o_result,
    output logic                               o_result_valid
);

    localparam int SUM_W    = lrp_pkg::VALUE_W + 4;
    localparam int ANGLE_W  = 16;
    localparam int CNT_W    = 6;
    localparam logic [ANGLE_W-1:0] AngleMax   = ANGLE_W'(36000);
    localparam logic [ANGLE_W-1:0] HalfSector = ANGLE_W'(lrp_pkg::SECTOR_WIDTH_DEG * 50);
    localparam int                 SectorSpan = lrp_pkg::SECTOR_WIDTH_DEG * 100;
    localparam logic [lrp_pkg::LEN_W-1:0] LenLimit =
        lrp_pkg::LEN_W'(lrp_pkg::FIELD_BUFFER_BYTES - 1);

    logic                          r_skip, n_skip;
    logic                          r_await, n_await;
    logic                          r_sel, n_sel;
    logic [lrp_pkg::LEN_W-1:0]     r_len  [2];
    logic [lrp_pkg::LEN_W-1:0]     n_len  [2];
    logic [lrp_pkg::VALUE_W-1:0]   r_acc  [2];
    logic [lrp_pkg::VALUE_W-1:0]   n_acc  [2];
    logic [1:0]                    r_pts  [2];
    logic [1:0]                    n_pts  [2];
    logic [1:0]                    r_frac [2];
    logic [1:0]                    n_frac [2];

    logic                          is_eol, is_digit;
    logic [3:0]                    digit;
    logic [SUM_W-1:0]              int_sum, frac_sum;
    logic [lrp_pkg::LEN_W-1:0]     len_inc;
    logic [ANGLE_W-1:0]            angle, adj;
    logic [CNT_W-1:0]              sec_cnt;

    assign is_eol   = (i_rx_char == lrp_pkg::CH_CR) || (i_rx_char == lrp_pkg::CH_LF);
    assign is_digit = (i_rx_char >= lrp_pkg::CH_ZERO) && (i_rx_char <= lrp_pkg::CH_NINE);
    assign digit    = 4'(i_rx_char - lrp_pkg::CH_ZERO);
    assign len_inc  = r_len[r_sel] + 1'b1;

    // integer digit shifts the value up; fraction digits land in tenths then hundredths
    assign int_sum  = {4'd0, r_acc[r_sel]} * SUM_W'(10) + SUM_W'(digit) * SUM_W'(100);
    assign frac_sum = {4'd0, r_acc[r_sel]}
                    + ((r_frac[r_sel] == 2'd0) ? SUM_W'(digit) * SUM_W'(10) : SUM_W'(digit));

    // sector: count of boundaries passed, valid up to 36000 and below the last boundary
    assign angle = r_acc[0][ANGLE_W-1:0];
    always_comb begin
        logic [ANGLE_W-1:0] raised;
        raised = angle + HalfSector;
        adj    = (raised > AngleMax) ? raised - AngleMax : raised;
        sec_cnt = '0;
        for (int k = 1; k < lrp_pkg::SECTOR_COUNT; k++) begin
            if (32'(adj) >= 32'(k * SectorSpan)) begin
                sec_cnt = sec_cnt + 1'b1;
            end
        end
    end

    always_comb begin
        logic in_range;
        in_range = (r_acc[0] <= lrp_pkg::VALUE_W'(36000))
                && (32'(adj) < 32'(lrp_pkg::SECTOR_COUNT * SectorSpan));
        o_result.first_value    = r_acc[0];
        o_result.second_present = r_sel && (r_len[1] != '0);
        o_result.second_value   = o_result.second_present ? r_acc[1] : '0;
        o_result.sector_valid   = in_range;
        o_result.sector_index   = in_range ? sec_cnt[lrp_pkg::IDX_W-1:0] : '0;
        o_result_valid          = i_char_accept && is_eol && (r_len[0] != '0);
    end

    always_comb begin
        logic clear;
        clear   = 1'b0;
        n_skip  = r_skip;
        n_await = r_await;
        n_sel   = r_sel;
        n_len   = r_len;
        n_acc   = r_acc;
        n_pts   = r_pts;
        n_frac  = r_frac;
        if (i_char_accept) begin
            priority if (is_eol) begin
                clear   = 1'b1;
                n_skip  = 1'b0;
                n_await = 1'b0;
            end else if (i_rx_char == lrp_pkg::CH_HASH || r_skip) begin
                n_skip = 1'b1;
            end else if (i_rx_char == lrp_pkg::CH_QUERY) begin
                n_await = 1'b1;
            end else if (r_await) begin
                if (i_rx_char == lrp_pkg::CH_SPACE) begin
                    n_await = 1'b0;
                end
            end else if (i_rx_char == lrp_pkg::CH_COMMA) begin
                if (!r_sel && r_len[0] != '0) begin
                    n_sel = 1'b1;
                end else begin
                    clear  = 1'b1;
                    n_skip = 1'b1;
                end
            end else if (is_digit || i_rx_char == lrp_pkg::CH_POINT) begin
                if (!is_digit) begin
                    if (r_pts[r_sel] != 2'd2) begin
                        n_pts[r_sel] = r_pts[r_sel] + 1'b1;
                    end
                end else if (r_pts[r_sel] == 2'd0) begin
                    n_acc[r_sel] = (int_sum > SUM_W'(lrp_pkg::VALUE_MAX))
                                 ? lrp_pkg::VALUE_MAX : int_sum[lrp_pkg::VALUE_W-1:0];
                end else if (r_pts[r_sel] == 2'd1 && r_frac[r_sel] != 2'd2) begin
                    n_frac[r_sel] = r_frac[r_sel] + 1'b1;
                    n_acc[r_sel]  = (frac_sum > SUM_W'(lrp_pkg::VALUE_MAX))
                                  ? lrp_pkg::VALUE_MAX : frac_sum[lrp_pkg::VALUE_W-1:0];
                end
                n_len[r_sel] = len_inc;
                if (len_inc >= LenLimit) begin
                    clear  = 1'b1;
                    n_skip = 1'b1;
                end
            end
        end
        if (clear) begin
            n_sel = 1'b0;
            for (int k = 0; k < 2; k++) begin
                n_len[k]  = '0;
                n_acc[k]  = '0;
                n_pts[k]  = '0;
                n_frac[k] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip  <= 1'b0;
            r_await <= 1'b0;
            r_sel   <= 1'b0;
            for (int k = 0; k < 2; k++) begin
                r_len[k]  <= '0;
                r_acc[k]  <= '0;
                r_pts[k]  <= '0;
                r_frac[k] <= '0;
            end
        end else begin
            r_skip  <= n_skip;
            r_await <= n_await;
            r_sel   <= n_sel;
            r_len   <= n_len;
            r_acc   <= n_acc;
            r_pts   <= n_pts;
            r_frac  <= n_frac;
        end
    end

endmodule
`default_nettype wire

/* test/lidar_reply_line_parser_test.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// lidar_reply_line_parser_test: character-stream check of the reply line parser
// Sends short directed lines, then mostly well-formed random reply lines mixed
// with comment, query, third-field, over-long and noise lines. Every accepted
// character goes through a cycle-free model of the parser. Every delivered
// line is compared field by field against the oldest predicted line.
// ---------------------------------------------------------------------------
module lidar_reply_line_parser_test;

    localparam int CLK_PERIOD     = 20;
    localparam int RESET_CYCLES   = 8;
    localparam int CHAR_TARGET    = 1150;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 10;
    localparam int ANGLE_FULL     = 36000;

    typedef logic [lrp_pkg::CHAR_W-1:0] t_char;
    typedef enum int {STALL_NONE, STALL_COIN, STALL_RARE, STALL_HEAVY} t_stall_mode;

    // Line model: tracks the parser state per character and keeps the
    // lines that are still to come out of the block.
    class line_result_tracker;
        lrp_pkg::t_result    expected_lines[$];
        int                  mismatches;
        bit                  skip_line;
        bit                  await_space;
        int                  field_sel;
        int                  field_len[2];
        longint unsigned     field_acc[2];
        int                  points[2];
        int                  frac_digits[2];

        function void clear_fields();
            field_sel = 0;
            for (int k = 0; k < 2; k++) begin
                field_len[k]   = 0;
                field_acc[k]   = 0;
                points[k]      = 0;
                frac_digits[k] = 0;
            end
        endfunction

        function void reset_state();
            skip_line   = 0;
            await_space = 0;
            mismatches  = 0;
            clear_fields();
        endfunction

        function longint unsigned saturate(longint unsigned v);
            return (v > 64'(lrp_pkg::VALUE_MAX)) ? 64'(lrp_pkg::VALUE_MAX) : v;
        endfunction

        function void add_char(int k, t_char c);
            longint unsigned d;
            if (c == lrp_pkg::CH_POINT) begin
                if (points[k] < 2) points[k]++;
            end else begin
                d = 64'(c) - 64'(lrp_pkg::CH_ZERO);
                if (points[k] == 0) begin
                    field_acc[k] = saturate(field_acc[k] * 10 + d * 100);
                end else if (points[k] == 1 && frac_digits[k] < 2) begin
                    frac_digits[k]++;
                    field_acc[k] = saturate(field_acc[k] + ((frac_digits[k] == 1) ? d * 10 : d));
                end
            end
        endfunction

        function lrp_pkg::t_result finish_line();
            lrp_pkg::t_result r;
            longint unsigned  a;
            longint unsigned  adj;
            longint unsigned  sec;
            a = field_acc[0];
            r.first_value    = a[lrp_pkg::VALUE_W-1:0];
            r.second_present = (field_sel == 1) && (field_len[1] > 0);
            r.second_value   = r.second_present ? field_acc[1][lrp_pkg::VALUE_W-1:0] : '0;
            r.sector_index   = '0;
            r.sector_valid   = 1'b0;
            if (a <= 64'(ANGLE_FULL)) begin
                // half-sector offset centers sector 0 on zero degrees
                adj = a + 64'(lrp_pkg::SECTOR_WIDTH_DEG * 50);
                if (adj > 64'(ANGLE_FULL)) adj -= 64'(ANGLE_FULL);
                sec = adj / 64'(lrp_pkg::SECTOR_WIDTH_DEG * 100);
                if (sec < 64'(lrp_pkg::SECTOR_COUNT)) begin
                    r.sector_valid = 1'b1;
                    r.sector_index = sec[lrp_pkg::IDX_W-1:0];
                end
            end
            return r;
        endfunction

        // Called once per accepted input transaction.
        function void take_char(t_char c);
            int k;
            if (c == lrp_pkg::CH_CR || c == lrp_pkg::CH_LF) begin
                if (field_len[0] > 0) expected_lines.push_back(finish_line());
                clear_fields();
                skip_line   = 0;
                await_space = 0;
            end else if (c == lrp_pkg::CH_HASH || skip_line) begin
                skip_line = 1;
            end else if (c == lrp_pkg::CH_QUERY) begin
                await_space = 1;
            end else if (await_space) begin
                if (c == lrp_pkg::CH_SPACE) await_space = 0;
            end else if (c == lrp_pkg::CH_COMMA) begin
                if (field_sel == 0 && field_len[0] > 0) begin
                    field_sel = 1;
                end else begin
                    clear_fields();
                    skip_line = 1;
                end
            end else if ((c >= lrp_pkg::CH_ZERO && c <= lrp_pkg::CH_NINE) ||
                         c == lrp_pkg::CH_POINT) begin
                k = field_sel;
                add_char(k, c);
                field_len[k]++;
                if (field_len[k] >= lrp_pkg::FIELD_BUFFER_BYTES - 1) begin
                    clear_fields();
                    skip_line = 1;
                end
            end
        endfunction

        function int pending();
            return expected_lines.size();
        endfunction

        task report(string what, longint unsigned got, longint unsigned want);
            $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
            mismatches++;
        endtask

        // Called once per accepted output transaction.
        task check_line(lrp_pkg::t_result got);
            lrp_pkg::t_result want;
            if (expected_lines.size() == 0) begin
                report("unexpected line, first_value", got.first_value, 0);
            end else begin
                want = expected_lines.pop_front();
                if (got.first_value !== want.first_value)
                    report("first_value", got.first_value, want.first_value);
                if (got.second_value !== want.second_value)
                    report("second_value", got.second_value, want.second_value);
                if (got.second_present !== want.second_present)
                    report("second_present", got.second_present, want.second_present);
                if (got.sector_index !== want.sector_index)
                    report("sector_index", got.sector_index, want.sector_index);
                if (got.sector_valid !== want.sector_valid)
                    report("sector_valid", got.sector_valid, want.sector_valid);
            end
        endtask
    endclass

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_in_valid;
    logic                          o_in_stall;
    t_char                         i_rx_char;
    logic                          o_out_valid;
    logic                          i_out_stall;
    logic [lrp_pkg::VALUE_W-1:0]   o_first_value;
    logic [lrp_pkg::VALUE_W-1:0]   o_second_value;
    logic                          o_second_present;
    logic [lrp_pkg::IDX_W-1:0]     o_sector_index;
    logic                          o_sector_valid;

    line_result_tracker    tracker;
    t_char                 line_chars[$];
    int                    burst_left;
    int                    chars_sent;
    int                    idle_cycles;
    lrp_pkg::t_result      seen;

    lidar_reply_line_parser u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_rx_char        (i_rx_char),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_first_value    (o_first_value),
        .o_second_value   (o_second_value),
        .o_second_present (o_second_present),
        .o_sector_index   (o_sector_index),
        .o_sector_valid   (o_sector_valid)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Sender works in bursts; the gap before a burst may be empty.
    task automatic send_char(t_char c);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_rx_char  <= c;
        do @(posedge i_clk); while (o_in_stall);
        tracker.take_char(c);
        chars_sent++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i]);
    endtask

    task automatic send_queued();
        while (line_chars.size() > 0) send_char(line_chars.pop_front());
    endtask

    function automatic t_char rand_digit();
        return lrp_pkg::CH_ZERO + t_char'($urandom_range(0, 9));
    endfunction

    function automatic t_char rand_byte();
        return t_char'($urandom_range(0, 255));
    endfunction

    function automatic void add_decimal(int unsigned v);
        string s;
        s = $sformatf("%0d", v);
        for (int i = 0; i < s.len(); i++) line_chars.push_back(s[i]);
    endfunction

    function automatic void add_digits(int n);
        for (int i = 0; i < n; i++) line_chars.push_back(rand_digit());
    endfunction

    // A byte the parser simply ignores.
    function automatic void add_junk();
        t_char b;
        do begin
            b = rand_byte();
        end while (b == lrp_pkg::CH_CR || b == lrp_pkg::CH_LF || b == lrp_pkg::CH_HASH ||
                   b == lrp_pkg::CH_QUERY || b == lrp_pkg::CH_COMMA ||
                   b == lrp_pkg::CH_POINT ||
                   (b >= lrp_pkg::CH_ZERO && b <= lrp_pkg::CH_NINE));
        line_chars.push_back(b);
    endfunction

    function automatic void add_terminator();
        case ($urandom_range(0, 2))
            0: line_chars.push_back(lrp_pkg::CH_CR);
            1: line_chars.push_back(lrp_pkg::CH_LF);
            default: begin
                line_chars.push_back(lrp_pkg::CH_CR);
                line_chars.push_back(lrp_pkg::CH_LF);
            end
        endcase
    endfunction

    // One numeric field, at most 14 characters.
    function automatic void add_field();
        int unsigned h;
        int unsigned sel;
        int          kind;
        kind = $urandom_range(0, 9);
        if (kind < 5) begin
            if ($urandom_range(0, 2) == 0) begin
                // near a sector edge or the full-circle limit
                sel = $urandom_range(0, 8);
                h = (sel == 8) ? ANGLE_FULL
                               : sel * lrp_pkg::SECTOR_WIDTH_DEG * 100
                                 + lrp_pkg::SECTOR_WIDTH_DEG * 50;
                h = h - 1 + $urandom_range(0, 2);
            end else begin
                h = $urandom_range(0, 37000);
            end
            if (h >= 100 || $urandom_range(0, 3) != 0) add_decimal(h / 100);
            case ($urandom_range(0, 3))
                0: ;
                1: begin
                    line_chars.push_back(lrp_pkg::CH_POINT);
                    add_decimal((h % 100) / 10);
                end
                2: begin
                    line_chars.push_back(lrp_pkg::CH_POINT);
                    add_decimal((h % 100) / 10);
                    add_decimal(h % 10);
                end
                default: begin
                    line_chars.push_back(lrp_pkg::CH_POINT);
                    add_decimal((h % 100) / 10);
                    add_decimal(h % 10);
                    add_digits($urandom_range(1, 2));
                    if ($urandom_range(0, 1) == 0) begin
                        line_chars.push_back(lrp_pkg::CH_POINT);
                        add_digits($urandom_range(0, 2));
                    end
                end
            endcase
        end else if (kind < 7) begin
            add_digits($urandom_range(6, 14));
        end else if (kind == 7) begin
            repeat ($urandom_range(1, 3)) line_chars.push_back(lrp_pkg::CH_POINT);
        end else begin
            repeat ($urandom_range(1, 8))
                line_chars.push_back(($urandom_range(0, 4) == 0) ? lrp_pkg::CH_POINT
                                                                 : rand_digit());
        end
    endfunction

    function automatic void build_line();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            if ($urandom_range(0, 9) == 0) begin
                line_chars.push_back(lrp_pkg::CH_QUERY);
                repeat ($urandom_range(0, 3)) add_junk();
                line_chars.push_back(lrp_pkg::CH_SPACE);
            end
            add_field();
            if ($urandom_range(0, 7) == 0) add_junk();
            if ($urandom_range(0, 9) < 6) begin
                line_chars.push_back(lrp_pkg::CH_COMMA);
                if ($urandom_range(0, 7) != 0) add_field();
            end
            if ($urandom_range(0, 7) == 0) add_junk();
        end else if (pick < 68) begin
            if ($urandom_range(0, 1) == 0) add_field();
            line_chars.push_back(lrp_pkg::CH_HASH);
            repeat ($urandom_range(0, 6)) line_chars.push_back(rand_byte());
        end else if (pick < 76) begin
            if ($urandom_range(0, 2) != 0) begin
                add_field();
                line_chars.push_back(lrp_pkg::CH_COMMA);
                add_field();
            end
            line_chars.push_back(lrp_pkg::CH_COMMA);
            add_field();
        end else if (pick < 84) begin
            if ($urandom_range(0, 1) == 0) begin
                add_field();
                line_chars.push_back(lrp_pkg::CH_COMMA);
            end
            repeat ($urandom_range(15, 18))
                line_chars.push_back(($urandom_range(0, 5) == 0) ? lrp_pkg::CH_POINT
                                                                 : rand_digit());
            if ($urandom_range(0, 1) == 0) add_digits(2);
        end else begin
            repeat ($urandom_range(1, 10)) line_chars.push_back(rand_byte());
        end
        add_terminator();
    endfunction

    // Receiver stall pattern, switching between quiet, coin-flip, rare and heavy.
    initial begin
        t_stall_mode mode;
        int          span;
        i_out_stall = 1'b0;
        forever begin
            mode = t_stall_mode'($urandom_range(0, 3));
            span = $urandom_range(20, 200);
            repeat (span) begin
                @(negedge i_clk);
                case (mode)
                    STALL_NONE:  i_out_stall <= 1'b0;
                    STALL_COIN:  i_out_stall <= 1'($urandom_range(0, 1));
                    STALL_RARE:  i_out_stall <= ($urandom_range(0, 7) == 0);
                    STALL_HEAVY: i_out_stall <= ($urandom_range(0, 7) != 0);
                    default:     i_out_stall <= 1'b0;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen.first_value    = o_first_value;
            seen.second_value   = o_second_value;
            seen.second_present = o_second_present;
            seen.sector_index   = o_sector_index;
            seen.sector_valid   = o_sector_valid;
            tracker.check_line(seen);
        end
    end

    // Watchdog on cycles with no transaction on either side.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("[lidar_reply_line_parser] ERROR");
                $finish;
            end
        end
    end

    initial begin
        tracker = new();
        tracker.reset_state();
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_rx_char   = '0;
        burst_left  = 0;
        chars_sent  = 0;
        idle_cycles = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: full-circle angle, points-only second field, comment line,
        // query skip up to space, leading comma, third field
        send_text("360");
        send_char(lrp_pkg::CH_CR);
        send_text("0");
        send_char(lrp_pkg::CH_COMMA);
        send_char(lrp_pkg::CH_POINT);
        send_char(lrp_pkg::CH_LF);
        send_char(lrp_pkg::CH_HASH);
        send_text("1");
        send_char(lrp_pkg::CH_LF);
        send_char(lrp_pkg::CH_QUERY);
        send_text("9");
        send_char(lrp_pkg::CH_SPACE);
        send_text("5");
        send_char(lrp_pkg::CH_LF);
        send_char(lrp_pkg::CH_COMMA);
        send_text("1");
        send_char(lrp_pkg::CH_LF);
        send_text("1");
        send_char(lrp_pkg::CH_COMMA);
        send_text("2");
        send_char(lrp_pkg::CH_COMMA);
        send_text("3");
        send_char(lrp_pkg::CH_LF);

        while (chars_sent < CHAR_TARGET) begin
            build_line();
            send_queued();
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (tracker.mismatches == 0) begin
            $display("[lidar_reply_line_parser] OK");
        end else begin
            $display("[lidar_reply_line_parser] ERROR");
        end
        $finish;
    end

endmodule
